// ----- rtl/allc_pkg.sv -----
`timescale 1ns / 1ps

package allc_pkg;

   localparam int SAMPLE_W       = 10;
   localparam int CODE_W         = 3;
   localparam int LEVEL_W        = 2;
   localparam int SUM_W          = 16;
   localparam int THRESH_W       = 10;
   localparam int CSR_IDX_W      = 2;
   localparam int CSR_DATA_W     = 10;
   localparam int WINDOW_DEFAULT = 8;

   localparam logic [THRESH_W-1:0] OFF_HOLD_RESET   = THRESH_W'(650);
   localparam logic [THRESH_W-1:0] OFF_ENTER_RESET  = THRESH_W'(850);
   localparam logic [THRESH_W-1:0] FULL_ENTER_RESET = THRESH_W'(350);
   localparam logic [THRESH_W-1:0] FULL_EXIT_RESET  = THRESH_W'(500);

   // Lamp level held in bits 2:1 of the light code.
   typedef enum logic [LEVEL_W-1:0] {
      LVL_OFF  = 2'd0,
      LVL_PARK = 2'd1,
      LVL_RSVD = 2'd2,
      LVL_FULL = 2'd3
   } level_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OFF_HOLD   = 2'd0,
      CSR_OFF_ENTER  = 2'd1,
      CSR_FULL_ENTER = 2'd2,
      CSR_FULL_EXIT  = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [THRESH_W-1:0] off_hold;
      logic [THRESH_W-1:0] off_enter;
      logic [THRESH_W-1:0] full_enter;
      logic [THRESH_W-1:0] full_exit;
   } thresh_type;

endpackage

// ----- rtl/allc_req_if.sv -----
`timescale 1ns / 1ps

interface allc_req_if import allc_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] sample;
   logic [CODE_W-1:0]   light_code;

   modport source (output valid, output sample, output light_code, input ready);
   modport sink   (input valid, input sample, input light_code, output ready);
endinterface

// ----- rtl/allc_rsp_if.sv -----
`timescale 1ns / 1ps

interface allc_rsp_if import allc_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [CODE_W-1:0]   new_light_code;
   logic [SAMPLE_W-1:0] mean_level;

   modport source (output valid, output new_light_code, output mean_level, input ready);
   modport sink   (input valid, input new_light_code, input mean_level, output ready);
endinterface

// ----- rtl/ambient_light_level_classifier_top.sv -----
`timescale 1ns / 1ps

// Ambient light level classifier.
// Request channel (req_if): one 10-bit light sample plus a 3-bit light code
// (bit 0 aux flag, bits 2:1 current lamp level: 0 off, 1 parking, 3 full).
// Response channel (rsp_if): the new light code (aux passed through, new
// level in bits 2:1) and the windowed mean that drove the decision.
// Each request pushes its sample into a ring of WINDOW samples; the mean is
// the running sum divided by WINDOW, and hysteresis thresholds picked by the
// current level choose the new level. Level code 2 always yields off.
// Thresholds come from four CSRs written through csr_wr_en/csr_index/csr_wdata;
// write them only while no request is in flight.
// Two stages: ring/sum update, then divide and classify.
// Throughput: one request per cycle while rsp_if.ready keeps the response
// draining; the ring memory has one write and one prefetch read port, so a
// new sample never waits on the previous one.
// Reset clears the ring (through per-entry valid bits), the position, the
// sum and both pipeline stages, and loads the threshold defaults.
// When the receiver stalls, the response holds, the middle stage fills,
// and req_if.ready drops until rsp_if.ready returns.
module ambient_light_level_classifier_top import allc_pkg::*; #(
   parameter int WINDOW = WINDOW_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   allc_req_if.sink              req_if,
   allc_rsp_if.source            rsp_if,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // Threshold registers.
   thresh_type thresh_ff;

   // Stage 1: updated sum and code of the request.
   logic                s1_vld_ff;
   logic [SUM_W-1:0]    s1_sum_ff;
   logic [CODE_W-1:0]   s1_code_ff;

   // Stage 2: response register.
   logic                out_vld_ff;
   logic [CODE_W-1:0]   out_code_ff;
   logic [SAMPLE_W-1:0] out_mean_ff;

   logic                accept;
   logic                s1_free;
   logic                out_load;
   logic [SUM_W-1:0]    sum_new;
   logic [CODE_W-1:0]   cls_code;
   logic [SAMPLE_W-1:0] cls_mean;

   // Advance the response register when it is empty or being drained;
   // advance stage 1 when it is empty or moving on.
   assign out_load     = s1_vld_ff && (!out_vld_ff || rsp_if.ready);
   assign s1_free      = !s1_vld_ff || out_load;
   assign req_if.ready = s1_free;
   assign accept       = req_if.valid && s1_free;

   // Ring of samples and running sum, updated once per accepted request.
   allc_window #(
      .WINDOW (WINDOW)
   ) u_window (
      .clock   (clock),
      .reset   (reset),
      .load    (accept),
      .sample  (req_if.sample),
      .sum_new (sum_new)
   );

   // Divide by WINDOW and pick the new level.
   allc_classify #(
      .WINDOW (WINDOW)
   ) u_classify (
      .sum            (s1_sum_ff),
      .light_code     (s1_code_ff),
      .thresh         (thresh_ff),
      .new_light_code (cls_code),
      .mean_level     (cls_mean)
   );

   // CSR writes: drop nothing, every index maps to a threshold.
   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff.off_hold   <= OFF_HOLD_RESET;
         thresh_ff.off_enter  <= OFF_ENTER_RESET;
         thresh_ff.full_enter <= FULL_ENTER_RESET;
         thresh_ff.full_exit  <= FULL_EXIT_RESET;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_OFF_HOLD:   thresh_ff.off_hold   <= THRESH_W'(csr_wdata);
            CSR_OFF_ENTER:  thresh_ff.off_enter  <= THRESH_W'(csr_wdata);
            CSR_FULL_ENTER: thresh_ff.full_enter <= THRESH_W'(csr_wdata);
            CSR_FULL_EXIT:  thresh_ff.full_exit  <= THRESH_W'(csr_wdata);
            default: begin
            end
         endcase
      end
   end

   // Pipeline valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         if (s1_free) begin
            s1_vld_ff <= req_if.valid;
         end
         if (out_load) begin
            out_vld_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            out_vld_ff <= 1'b0;
         end
      end
   end

   // Pipeline payload; hold while stalled.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_sum_ff  <= sum_new;
         s1_code_ff <= req_if.light_code;
      end
      if (out_load) begin
         out_code_ff <= cls_code;
         out_mean_ff <= cls_mean;
      end
   end

   assign rsp_if.valid          = out_vld_ff;
   assign rsp_if.new_light_code = out_code_ff;
   assign rsp_if.mean_level     = out_mean_ff;

   // A response never carries the reserved level code.
   a_no_rsvd_level: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff |-> (level_type'(out_code_ff[CODE_W-1:1]) != LVL_RSVD))
      else $error("response carries reserved level code");

   // The reserved level code on a request forces the lamps off.
   a_rsvd_forces_off: assert property (@(posedge clock) disable iff (reset)
      (out_load && (level_type'(s1_code_ff[CODE_W-1:1]) == LVL_RSVD))
      |=> (level_type'(out_code_ff[CODE_W-1:1]) == LVL_OFF))
      else $error("reserved level code did not force off");

   // The aux flag passes through the classifier unchanged.
   a_aux_passthru: assert property (@(posedge clock) disable iff (reset)
      out_load |=> (out_code_ff[0] == $past(s1_code_ff[0])))
      else $error("aux flag changed in flight");

   // A stalled stage 1 keeps its request.
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_vld_ff && !out_load) |=> (s1_vld_ff && $stable(s1_sum_ff)
                                    && $stable(s1_code_ff)))
      else $error("stage 1 lost a stalled request");

endmodule

// ----- rtl/allc_window.sv -----
`timescale 1ns / 1ps

module allc_window import allc_pkg::*; #(
   parameter int WINDOW = WINDOW_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  logic [SAMPLE_W-1:0] sample,
   output logic [SUM_W-1:0]    sum_new
);

   localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam logic [PTR_W-1:0] LAST_POS = PTR_W'(WINDOW - 1);

   logic [SAMPLE_W-1:0] ring_mem [WINDOW];
   logic [WINDOW-1:0]   vld_ff;
   logic [PTR_W-1:0]    pos_ff;
   logic [SUM_W-1:0]    sum_ff;
   logic [SAMPLE_W-1:0] rd_data_ff;
   logic                rd_vld_ff;
   logic                byp_ff;
   logic [SAMPLE_W-1:0] byp_data_ff;

   logic [PTR_W-1:0]    pos_inc;
   logic [PTR_W-1:0]    rd_addr;
   logic                hazard;
   logic [SAMPLE_W-1:0] old_sample;

   assign pos_inc = (pos_ff == LAST_POS) ? '0 : pos_ff + PTR_W'(1);
   // Prefetch the entry that the next sample replaces.
   assign rd_addr = load ? pos_inc : pos_ff;
   assign hazard  = load && (rd_addr == pos_ff);

   assign old_sample = byp_ff    ? byp_data_ff :
                       rd_vld_ff ? rd_data_ff  : '0;

   assign sum_new = sum_ff - SUM_W'(old_sample) + SUM_W'(sample);

   always_ff @(posedge clock) begin
      if (load) begin
         ring_mem[pos_ff] <= sample;
      end
      rd_data_ff  <= ring_mem[rd_addr];
      byp_data_ff <= sample;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         pos_ff    <= '0;
         sum_ff    <= '0;
         rd_vld_ff <= 1'b0;
         byp_ff    <= 1'b0;
      end else begin
         rd_vld_ff <= vld_ff[rd_addr];
         byp_ff    <= hazard;
         if (load) begin
            vld_ff[pos_ff] <= 1'b1;
            pos_ff         <= pos_inc;
            sum_ff         <= sum_new;
         end
      end
   end

endmodule

// ----- rtl/allc_classify.sv -----
`timescale 1ns / 1ps

module allc_classify import allc_pkg::*; #(
   parameter int WINDOW = WINDOW_DEFAULT
) (
   input  logic [SUM_W-1:0]    sum,
   input  logic [CODE_W-1:0]   light_code,
   input  thresh_type          thresh,
   output logic [CODE_W-1:0]   new_light_code,
   output logic [SAMPLE_W-1:0] mean_level
);

   // Exact divide by WINDOW over the whole sum range: multiply by the
   // rounded-up reciprocal and drop the fraction bits.
   localparam int    DIV_SHIFT = SUM_W + $clog2(WINDOW);
   localparam int    RECIP_W   = DIV_SHIFT + 1;
   localparam int    PROD_W    = SUM_W + RECIP_W;
   localparam longint RECIP_VAL = ((64'd1 << DIV_SHIFT) + WINDOW - 1) / WINDOW;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);

   logic [PROD_W-1:0]   prod;
   level_type           level;
   level_type           next_level;
   logic [THRESH_W-1:0] off_th;
   logic [THRESH_W-1:0] park_th;
   logic                force_off;

   assign prod       = PROD_W'(sum) * PROD_W'(RECIP);
   assign mean_level = prod[DIV_SHIFT +: SAMPLE_W];
   assign level      = level_type'(light_code[CODE_W-1:1]);

   always_comb begin
      off_th    = thresh.off_enter;
      park_th   = thresh.full_enter;
      force_off = 1'b0;
      case (level)
         LVL_OFF: begin
            off_th  = thresh.off_hold;
            park_th = thresh.full_enter;
         end
         LVL_PARK: begin
            off_th  = thresh.off_enter;
            park_th = thresh.full_enter;
         end
         LVL_FULL: begin
            off_th  = thresh.off_enter;
            park_th = thresh.full_exit;
         end
         default: begin
            force_off = 1'b1;
         end
      endcase

      if (force_off || (mean_level > off_th)) begin
         next_level = LVL_OFF;
      end else if (mean_level > park_th) begin
         next_level = LVL_PARK;
      end else begin
         next_level = LVL_FULL;
      end
   end

   assign new_light_code = {next_level, light_code[0]};

endmodule

// ----- verif/ambient_light_level_classifier_top_tb.sv -----
`timescale 1ns / 1ps

module ambient_light_level_classifier_top_tb;
   import allc_pkg::*;

   localparam int RING_DEPTH       = WINDOW_DEFAULT;
   localparam int SETTINGS_COUNT   = 12;
   localparam int REQS_PER_SETTING = 158;
   localparam int LONG_HOLD_CYCLES = 240;
   localparam int LONG_HOLD_AFTER  = 300;
   localparam int DRAIN_CYCLES     = 8;
   localparam int CYCLE_LIMIT      = 300000;

   // One light request as it goes into the block.
   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic [CODE_W-1:0]   light_code;
   } light_request_type;

   // One classification as it should come out of the block.
   typedef struct packed {
      logic [CODE_W-1:0]   new_light_code;
      logic [SAMPLE_W-1:0] mean_level;
   } light_decision_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   allc_req_if req_ch ();
   allc_rsp_if rsp_ch ();

   ambient_light_level_classifier_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch.sink),
      .rsp_if    (rsp_ch.source),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #1 clock = ~clock;

   // Requests waiting to be offered, and decisions waiting to be seen.
   light_request_type  pending_requests[$];
   light_decision_type expected_decisions[$];

   // Shadow of the block: sample ring, write position, running sum and thresholds.
   logic [SAMPLE_W-1:0] shadow_ring [RING_DEPTH];
   int unsigned         shadow_position;
   logic [SUM_W-1:0]    shadow_sum;
   thresh_type          shadow_thresholds;

   int sender_idle_pct   = 8;
   int receiver_idle_pct = 77;
   int hold_off_left     = 0;
   bit long_hold_done    = 1'b0;

   int error_count       = 0;
   int requests_accepted = 0;
   int decisions_checked = 0;
   int settings_applied  = 0;
   int cycle_count       = 0;
   int level_seen [4];
   int light_trend       = 512;

   // Classify one accepted request: update the ring and sum, then apply hysteresis.
   function automatic light_decision_type classify_light(light_request_type req);
      light_decision_type  d;
      logic [SAMPLE_W-1:0] mean;
      logic [THRESH_W-1:0] off_limit;
      logic [THRESH_W-1:0] park_limit;
      level_type           next_level;
      bit                  forced_off;
      forced_off = 1'b0;
      off_limit  = shadow_thresholds.off_enter;
      park_limit = shadow_thresholds.full_enter;
      shadow_sum = shadow_sum - SUM_W'(shadow_ring[shadow_position]) + SUM_W'(req.sample);
      shadow_ring[shadow_position] = req.sample;
      shadow_position = (shadow_position + 1) % RING_DEPTH;
      mean = SAMPLE_W'(shadow_sum / RING_DEPTH);
      case (level_type'(req.light_code[2:1]))
         LVL_OFF: begin
            off_limit  = shadow_thresholds.off_hold;
            park_limit = shadow_thresholds.full_enter;
         end
         LVL_PARK: begin
            off_limit  = shadow_thresholds.off_enter;
            park_limit = shadow_thresholds.full_enter;
         end
         LVL_FULL: begin
            off_limit  = shadow_thresholds.off_enter;
            park_limit = shadow_thresholds.full_exit;
         end
         default: begin
            // reserved level always turns the lamps off
            forced_off = 1'b1;
         end
      endcase
      if (forced_off || mean > off_limit) begin
         next_level = LVL_OFF;
      end else if (mean > park_limit) begin
         next_level = LVL_PARK;
      end else begin
         next_level = LVL_FULL;
      end
      d.new_light_code = {next_level, req.light_code[0]};
      d.mean_level     = mean;
      return d;
   endfunction

   // Driver: predict on every accepted request, then offer the next one.
   always @(posedge clock) begin
      light_request_type next_req;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            expected_decisions.push_back(
               classify_light('{sample: req_ch.sample, light_code: req_ch.light_code}));
            requests_accepted++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (pending_requests.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
               next_req = pending_requests.pop_front();
               req_ch.valid      <= 1'b1;
               req_ch.sample     <= next_req.sample;
               req_ch.light_code <= next_req.light_code;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Receiver readiness: random stalls, plus one long hold-off counted here.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_off_left > 0) begin
         rsp_ch.ready  <= 1'b0;
         hold_off_left <= hold_off_left - 1;
      end else if (!long_hold_done && decisions_checked >= LONG_HOLD_AFTER) begin
         // hold off long enough that the pipeline fills and req ready drops
         rsp_ch.ready   <= 1'b0;
         hold_off_left  <= LONG_HOLD_CYCLES;
         long_hold_done <= 1'b1;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   // Monitor: compare every accepted response with the oldest prediction.
   always @(posedge clock) begin
      light_decision_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_decisions.size() == 0) begin
            $error("unexpected response: new_light_code %0d mean_level %0d",
                   rsp_ch.new_light_code, rsp_ch.mean_level);
            error_count++;
         end else begin
            want = expected_decisions.pop_front();
            if (rsp_ch.new_light_code !== want.new_light_code) begin
               $error("new_light_code mismatch: expected %0d, actual %0d",
                      want.new_light_code, rsp_ch.new_light_code);
               error_count++;
            end
            if (rsp_ch.mean_level !== want.mean_level) begin
               $error("mean_level mismatch: expected %0d, actual %0d",
                      want.mean_level, rsp_ch.mean_level);
               error_count++;
            end
            level_seen[want.new_light_code[2:1]]++;
            decisions_checked++;
         end
      end
   end

   // Watchdog: end the run if it takes far longer than any correct run would.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("ambient_light_level_classifier_top test failed");
         $finish;
      end
   end

   // Hold until every request is sent and every response has come back.
   // Check between edges, once the driver and monitor updates have settled.
   task automatic wait_until_drained();
      while (pending_requests.size() > 0 || req_ch.valid || expected_decisions.size() > 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_threshold(input csr_index_type idx,
                                  input logic [THRESH_W-1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_OFF_HOLD:   shadow_thresholds.off_hold   = value;
         CSR_OFF_ENTER:  shadow_thresholds.off_enter  = value;
         CSR_FULL_ENTER: shadow_thresholds.full_enter = value;
         CSR_FULL_EXIT:  shadow_thresholds.full_exit  = value;
         default: begin
         end
      endcase
   endtask

   task automatic program_thresholds(input thresh_type t);
      write_threshold(CSR_OFF_HOLD, t.off_hold);
      write_threshold(CSR_OFF_ENTER, t.off_enter);
      write_threshold(CSR_FULL_ENTER, t.full_enter);
      write_threshold(CSR_FULL_EXIT, t.full_exit);
      settings_applied++;
   endtask

   // Pick a threshold set: defaults, extremes, ordered and scrambled random ones.
   function automatic thresh_type choose_thresholds(int kind);
      thresh_type t;
      int         step;
      case (kind)
         0: t = '{OFF_HOLD_RESET, OFF_ENTER_RESET, FULL_ENTER_RESET, FULL_EXIT_RESET};
         1: t = '{10'd0, 10'd0, 10'd0, 10'd0};
         2: t = '{10'd1023, 10'd1023, 10'd1023, 10'd1023};
         3: begin
            // sensible ordering: full_enter <= full_exit <= off_hold <= off_enter
            step         = $urandom_range(50, 350);
            t.full_enter = THRESH_W'(step);
            step         = step + $urandom_range(0, 200);
            t.full_exit  = THRESH_W'(step);
            step         = step + $urandom_range(0, 200);
            t.off_hold   = THRESH_W'(step);
            step         = step + $urandom_range(0, 200);
            t.off_enter  = THRESH_W'((step > 1023) ? 1023 : step);
         end
         4: begin
            t.off_hold   = THRESH_W'($urandom_range(1023));
            t.off_enter  = THRESH_W'($urandom_range(1023));
            t.full_enter = THRESH_W'($urandom_range(1023));
            t.full_exit  = THRESH_W'($urandom_range(1023));
         end
         default: t = '{10'd1023, 10'd0, 10'd1023, 10'd0};
      endcase
      return t;
   endfunction

   // Queue light requests that follow a drifting trend, so the mean sweeps
   // through the thresholds; mix in jumps, rail values and reserved levels.
   task automatic queue_light_requests(input int count);
      light_request_type req;
      int                roll;
      int                value;
      level_type         lvl;
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(99);
         if (roll < 4) begin
            light_trend = $urandom_range(1023);
         end else begin
            light_trend = light_trend + $urandom_range(80) - 40;
         end
         if (light_trend < 0) light_trend = 0;
         if (light_trend > 1023) light_trend = 1023;
         roll = $urandom_range(99);
         if (roll < 4) begin
            value = 0;
         end else if (roll < 8) begin
            value = 1023;
         end else if (roll < 15) begin
            value = $urandom_range(1023);
         end else begin
            value = light_trend + $urandom_range(60) - 30;
            if (value < 0) value = 0;
            if (value > 1023) value = 1023;
         end
         roll = $urandom_range(99);
         if (roll < 10) begin
            lvl = LVL_RSVD;
         end else if (roll < 40) begin
            lvl = LVL_OFF;
         end else if (roll < 70) begin
            lvl = LVL_PARK;
         end else begin
            lvl = LVL_FULL;
         end
         req.sample     = SAMPLE_W'(value);
         req.light_code = {lvl, 1'($urandom_range(1))};
         pending_requests.push_back(req);
      end
   endtask

   initial begin
      light_request_type req;
      req_ch.valid      = 1'b0;
      req_ch.sample     = '0;
      req_ch.light_code = '0;
      rsp_ch.ready      = 1'b0;
      for (int i = 0; i < RING_DEPTH; i++) shadow_ring[i] = '0;
      shadow_position   = 0;
      shadow_sum        = '0;
      shadow_thresholds = choose_thresholds(0);
      for (int i = 0; i < 4; i++) level_seen[i] = 0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: fill the ring from empty with bright samples, hold at the rail,
      // then fall to dark, walking every light code so each level and the reserved
      // code meet the mean on both sides of the default thresholds.
      for (int n = 0; n < 24; n++) begin
         req.sample     = (n < 16) ? SAMPLE_W'(1023) : SAMPLE_W'(0);
         req.light_code = CODE_W'(n % 8);
         pending_requests.push_back(req);
      end
      wait_until_drained();

      // Random: four threshold settings per idling pattern.
      for (int s = 0; s < SETTINGS_COUNT; s++) begin
         if (s == 4) begin
            sender_idle_pct   = 77;
            receiver_idle_pct = 8;
         end else if (s == 8) begin
            sender_idle_pct   = 0;
            receiver_idle_pct = 0;
         end
         program_thresholds(choose_thresholds(s % 6));
         queue_light_requests(REQS_PER_SETTING);
         // pause the sender until every response of this setting is back
         wait_until_drained();
      end

      if (expected_decisions.size() != 0) begin
         $error("%0d responses never arrived", expected_decisions.size());
         error_count++;
      end

      $display("Run covered %0d requests under %0d threshold settings, %0d responses checked",
               requests_accepted, settings_applied, decisions_checked);
      $display("Decisions seen: off %0d, parking %0d, full %0d",
               level_seen[LVL_OFF], level_seen[LVL_PARK], level_seen[LVL_FULL]);
      if (error_count == 0) begin
         $display("ambient_light_level_classifier_top test passed");
      end else begin
         $display("ambient_light_level_classifier_top test failed");
      end
      $finish;
   end

endmodule
